[src/chu_pkg.sv]
// ----------------------------------------------------------------------------
// chu_pkg
// Shared types, operation codes and CRC column tables for the hash unit.
// ----------------------------------------------------------------------------
package chu_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned CRC16_W = 16;
    localparam int unsigned CRC16_IN_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [OP_W-1:0]   op_t;

    // operation codes
    localparam op_t OP_CRC16_X2_ADD = 3'd0;
    localparam op_t OP_CRC16_ADD    = 3'd1;
    localparam op_t OP_CRC64_ADD    = 3'd2;
    localparam op_t OP_CHAIN_START  = 3'd3;
    localparam op_t OP_CHAIN_CONT   = 3'd4;

    localparam word_t CRC64_POLY_REV = 64'hC96C5795D7870F42;
    localparam word_t CRC64_ONES     = 64'hFFFFFFFFFFFFFFFF;
    localparam logic [CRC16_W-1:0] CRC16_POLY = 16'hA6BC;
    localparam logic [CRC16_W-1:0] CRC16_ONES = 16'hFFFF;

    typedef logic [WORD_W-1:0][WORD_W-1:0]      c64_cols_t;
    typedef logic [CRC16_IN_W-1:0][CRC16_W-1:0] c16_cols_t;

    // result and chain write enable from the execute logic
    typedef struct packed {
        word_t hash;
        logic  chain_we;
    } exec_res_t;

    // CRC-64 register contribution of each single register bit (elaboration only)
    function automatic c64_cols_t build_c64_cols();
        c64_cols_t tab;
        word_t     r;
        for (int b = 0; b < WORD_W; b++) begin
            r = word_t'(1) << b;
            for (int k = 0; k < WORD_W; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC64_POLY_REV) : (r >> 1);
            end
            tab[b] = r;
        end
        return tab;
    endfunction

    // CRC-16 contribution of each of the 32 start bits (elaboration only)
    function automatic c16_cols_t build_c16_cols();
        c16_cols_t                tab;
        logic [CRC16_IN_W-1:0]    r;
        for (int b = 0; b < CRC16_IN_W; b++) begin
            r = (CRC16_IN_W)'(1) << b;
            for (int k = 0; k < CRC16_IN_W; k++) begin
                r = r[0] ? ((r >> 1) ^ {16'h0000, CRC16_POLY}) : (r >> 1);
            end
            tab[b] = r[CRC16_W-1:0];
        end
        return tab;
    endfunction

    localparam c64_cols_t CRC64_COLS = build_c64_cols();
    localparam c16_cols_t CRC16_COLS = build_c16_cols();

    // CRC-64/XZ of one word as a flat XOR network
    function automatic word_t crc64_word(word_t w);
        word_t x;
        word_t acc;
        x   = w ^ CRC64_ONES;
        acc = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) acc = acc ^ CRC64_COLS[i];
        end
        return acc ^ CRC64_ONES;
    endfunction

    // reflected CRC-16 of 32 bits, register preset to inverted data
    function automatic logic [CRC16_W-1:0] crc16_word(logic [CRC16_IN_W-1:0] w);
        logic [CRC16_IN_W-1:0] x;
        logic [CRC16_W-1:0]    acc;
        x   = ~w;
        acc = '0;
        for (int i = 0; i < CRC16_IN_W; i++) begin
            if (x[i]) acc = acc ^ CRC16_COLS[i];
        end
        return acc ^ CRC16_ONES;
    endfunction

endpackage

[src/crc_hash_execution_unit_top.sv]
// ----------------------------------------------------------------------------
// crc_hash_execution_unit_top
// Hash execute unit: CRC-16 / CRC-64/XZ hashes with add and chaining.
// ----------------------------------------------------------------------------
// Each word passes the input register, then the XOR network and add, then
// the output register, where it is held until m_tready takes it.
// Throughput: one word per cycle while m_tready does not stall the output.
// Op 4 sees the chain value left by the word just ahead of it without a
// bubble.
// Reset: synchronous active-low aresetn clears both valid flags and the
// chain value.
module crc_hash_execution_unit_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,   // [63:0] data, [127:64] addend
    input  chu_pkg::op_t          s_tuser,   // [2:0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output chu_pkg::word_t        m_tdata    // [63:0] hash_value
);
    import chu_pkg::*;

    logic      in_valid_reg;
    op_t       in_op_reg;
    word_t     in_data_reg;
    word_t     in_addend_reg;
    logic      out_valid_reg;
    word_t     out_hash_reg;
    word_t     chain_reg;
    word_t     chain_next;
    logic      out_load;
    logic      in_fire;
    exec_res_t res;

    // output register takes a word when empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_fire  = in_valid_reg && out_load;

    chu_exec u_exec (
        .op          (in_op_reg),
        .data        (in_data_reg),
        .addend      (in_addend_reg),
        .chain_value (chain_reg),
        .res         (res)
    );

    assign chain_next = (in_fire && res.chain_we) ? res.hash : chain_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg     <= s_tuser;
            in_data_reg   <= s_tdata[63:0];
            in_addend_reg <= s_tdata[127:64];
        end
    end

    // output register and chain value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end else begin
            chain_reg <= chain_next;
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
        if (in_fire) begin
            out_hash_reg <= res.hash;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

    // chain only moves on a chaining word leaving the input register
    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_fire && (in_op_reg == OP_CHAIN_START || in_op_reg == OP_CHAIN_CONT))
        |=> $stable(chain_reg))
        else $error("chain value changed without a chaining op");

    // chaining result lands in chain and output together
    a_chain_eq_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (in_op_reg == OP_CHAIN_START || in_op_reg == OP_CHAIN_CONT)
        |=> chain_reg == out_hash_reg)
        else $error("chain value differs from chained result");

    // undefined op gives zero
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_op_reg != OP_CRC16_X2_ADD && in_op_reg != OP_CRC16_ADD &&
        in_op_reg != OP_CRC64_ADD && in_op_reg != OP_CHAIN_START &&
        in_op_reg != OP_CHAIN_CONT
        |=> m_tdata == '0)
        else $error("undefined op gave non-zero result");

    // a held input word is not dropped while the output stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("input word lost during output stall");

endmodule

[src/chu_exec.sv]
// ----------------------------------------------------------------------------
// chu_exec
// Combinational execute logic: CRC network, add and chain update select.
// ----------------------------------------------------------------------------
module chu_exec (
    input  chu_pkg::op_t      op,
    input  chu_pkg::word_t    data,
    input  chu_pkg::word_t    addend,
    input  chu_pkg::word_t    chain_value,
    output chu_pkg::exec_res_t res
);
    import chu_pkg::*;

    logic [CRC16_W-1:0] crc16;
    word_t              crc64_in;
    word_t              crc64;

    // single CRC-16 network on data and single CRC-64 network, CRC-64 input muxed by op
    assign crc16 = crc16_word(data[CRC16_IN_W-1:0]);

    always_comb begin
        unique case (op)
            OP_CHAIN_START: crc64_in = data + addend;
            OP_CHAIN_CONT:  crc64_in = chain_value + data;
            default:        crc64_in = data;
        endcase
    end

    assign crc64 = crc64_word(crc64_in);

    // result select
    always_comb begin
        res.chain_we = 1'b0;
        unique case (op)
            OP_CRC16_X2_ADD: res.hash = {47'd0, crc16, 1'b0} + addend;
            OP_CRC16_ADD:    res.hash = {48'd0, crc16} + addend;
            OP_CRC64_ADD:    res.hash = crc64 + addend;
            OP_CHAIN_START, OP_CHAIN_CONT: begin
                res.hash     = crc64;
                res.chain_we = 1'b1;
            end
            default:         res.hash = '0;
        endcase
    end

endmodule
